// ===== rtl/core/stid_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table package
// Shared constants, status codes and the command bundle that the controller
// sends along the row of table cells.
// ----------------------------------------------------------------------------
package stid_pkg;

   // Fixed widths of the item fields.
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 6;
   localparam int STATUS_W     = 2;
   localparam int RSP_DATA_W   = 48;

   // Defaults for the top-level parameters.
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // Item kinds carried on req_tuser.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

   // Command broadcast to every cell in a cycle.
   typedef struct packed {
      logic insert;   // open a gap at the insert point and load the key
      logic shift;    // close the gap left by one equal entry
   } cell_cmd_type;

endpackage

// ===== rtl/core/stid_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry, compares it with the broadcast key and swaps data
// with its two neighbours on insert and delete steps.
// ----------------------------------------------------------------------------
module stid_cell #(
   parameter int INDEX       = 0,
   parameter int TABLE_DEPTH = stid_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = stid_pkg::VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  stid_pkg::cell_cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0]           key,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   input  logic                             prev_lt,
   input  logic [VALUE_WIDTH-1:0]           prev_entry,
   input  logic [VALUE_WIDTH-1:0]           next_entry,
   output logic [VALUE_WIDTH-1:0]           entry,
   output logic                             lt,
   output logic                             eq
);
   import stid_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   occupied;

   // Compare the held entry with the key; only occupied cells take part.
   always_comb begin
      occupied = CNT_W'(INDEX) < count;
      lt       = occupied && ($signed(entry_ff) < $signed(key));
      eq       = occupied && (entry_ff == key);
   end

   // Insert: cells at or past the insert point take the left neighbour's
   // entry, and the first of them takes the key. Delete step: cells at or
   // past the equal run take the right neighbour's entry.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !lt) begin
         entry_in = prev_lt ? key : prev_entry;
      end else if (cmd.shift && !lt) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/stid_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted table controller
// Takes items, drives the cell row one step a cycle (inserts wait for the
// result slot), counts entries, holds the result in an output register.
// ----------------------------------------------------------------------------
module stid_ctrl #(
   parameter int TABLE_DEPTH = stid_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = stid_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_action,
   input  logic [stid_pkg::DATA_W-1:0]          req_value,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [stid_pkg::STATUS_W-1:0]        rsp_status,
   output logic [stid_pkg::COUNT_W-1:0]         rsp_removed,
   output logic [stid_pkg::COUNT_W-1:0]         rsp_count,
   output logic [stid_pkg::DATA_W-1:0]          rsp_smallest,
   output stid_pkg::cell_cmd_type               cmd,
   output logic [VALUE_WIDTH-1:0]               key,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
   input  logic                                 any_eq,
   input  logic                                 lt0,
   input  logic [VALUE_WIDTH-1:0]               entry0
);
   import stid_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type               state_ff;
   logic                    action_ff;
   logic [VALUE_WIDTH-1:0]  key_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        removed_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic [COUNT_W-1:0]      removed_out_ff;
   logic [COUNT_W-1:0]      count_out_ff;
   logic [DATA_W-1:0]       smallest_ff;

   logic                    out_free;
   logic                    full;
   logic                    finish;
   logic [VALUE_WIDTH-1:0]  key_in;
   logic [VALUE_WIDTH-1:0]  smallest_raw;
   logic [CNT_W-1:0]        count_after;
   logic [VALUE_WIDTH+DATA_W-1:0] key_wide;
   logic [VALUE_WIDTH+DATA_W-1:0] smallest_wide;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   logic [CNT_W+COUNT_W-1:0] removed_wide;

   // Input value: low VALUE_WIDTH bits, zero-filled above the field width.
   always_comb begin
      key_wide = {{VALUE_WIDTH{1'b0}}, req_value};
      key_in   = key_wide[VALUE_WIDTH-1:0];
   end

   // Handshake and command decode.
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      full       = count_ff == CNT_W'(TABLE_DEPTH);
      req_tready = state_ff == S_IDLE;
      cmd.insert = (state_ff == S_EXEC) && (action_ff == ACT_INSERT) && !full && out_free;
      cmd.shift  = (state_ff == S_EXEC) && (action_ff == ACT_DELETE) && any_eq;
      finish     = (state_ff == S_EXEC) && !cmd.shift && out_free;
   end

   // Smallest entry once this item is done. On insert the key becomes the
   // head unless the table is full or the current head is already smaller.
   always_comb begin
      count_after = count_ff;
      if (action_ff == ACT_INSERT) begin
         if (!full) begin
            count_after = count_ff + 1'b1;
         end
         smallest_raw = (full || lt0) ? entry0 : key_ff;
      end else begin
         smallest_raw = (count_ff != '0) ? entry0 : '0;
      end
      smallest_wide = {{DATA_W{smallest_raw[VALUE_WIDTH-1]}}, smallest_raw};
      count_wide    = {{COUNT_W{1'b0}}, count_after};
      removed_wide  = {{COUNT_W{1'b0}}, removed_ff};
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A finishing item refills the result slot; otherwise a taken
         // result empties it.
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  action_ff  <= req_action;
                  key_ff     <= key_in;
                  removed_ff <= '0;
                  state_ff   <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (action_ff == ACT_DELETE && any_eq) begin
                  // One equal entry leaves the table per cycle.
                  count_ff   <= count_ff - 1'b1;
                  removed_ff <= removed_ff + 1'b1;
               end else if (out_free) begin
                  count_ff       <= count_after;
                  count_out_ff   <= count_wide[COUNT_W-1:0];
                  removed_out_ff <= removed_wide[COUNT_W-1:0];
                  smallest_ff    <= smallest_wide[DATA_W-1:0];
                  if (action_ff == ACT_INSERT) begin
                     status_ff <= full ? ST_FULL : ST_DONE;
                  end else begin
                     status_ff <= (removed_ff == '0) ? ST_NO_MATCH : ST_DONE;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_removed  = removed_out_ff;
   assign rsp_count    = count_out_ff;
   assign rsp_smallest = smallest_ff;
   assign key          = key_ff;
   assign count        = count_ff;

endmodule

// ===== rtl/core/sorted_table_insert_delete.sv =====
// ----------------------------------------------------------------------------
// Sorted table with insert and delete
// Keeps up to TABLE_DEPTH signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ stream: req_tuser selects insert (0) or delete (1)
// and req_tdata carries the value. Each item gives exactly one result item on
// the rsp_ stream with the status on rsp_tuser and the removed count, entry
// count and smallest entry packed in rsp_tdata.
// An insert places its value ahead of the first entry that is not smaller, so
// a new value lands ahead of equal ones; on a full table it is dropped and
// flagged. A delete removes every entry equal to its value.
// Operation: an insert is accepted, then every cell compares and shifts at
// once as soon as the result slot is free, and the result is registered.
// A delete removes its equal entries one per cycle, since the cell row
// closes the gap by one place per cycle, then registers its result.
// Reset empties the table (entry count zero). The result sits in an output
// register; if the receiver stalls, a following item is still accepted, but
// an insert does not shift and no item finishes until that register frees.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete #(
   parameter int TABLE_DEPTH = stid_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = stid_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [stid_pkg::DATA_W-1:0]        req_tdata,   // [31:0] value
   input  logic                               req_tuser,   // [0] action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] removed_count, [11:6] entry_count, [43:12] smallest_value,
   // [47:44] zero
   output logic [stid_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [stid_pkg::STATUS_W-1:0]      rsp_tuser    // [1:0] status
);
   import stid_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   cell_cmd_type             cmd;
   logic [VALUE_WIDTH-1:0]   key;
   logic [CNT_W-1:0]         count;
   logic [VALUE_WIDTH-1:0]   entries [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   lt_vec;
   logic [TABLE_DEPTH-1:0]   eq_vec;
   logic                     any_eq;
   logic [COUNT_W-1:0]       rsp_removed;
   logic [COUNT_W-1:0]       rsp_count;
   logic [DATA_W-1:0]        rsp_smallest;

   // A match anywhere in the row keeps the delete going.
   assign any_eq = |eq_vec;

   // Controller.
   stid_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_action   (req_tuser),
      .req_value    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_removed  (rsp_removed),
      .rsp_count    (rsp_count),
      .rsp_smallest (rsp_smallest),
      .cmd          (cmd),
      .key          (key),
      .count        (count),
      .any_eq       (any_eq),
      .lt0          (lt_vec[0]),
      .entry0       (entries[0])
   );

   // Row of cells; the ends see a fixed "smaller" on the left and their own
   // entry on the right.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                   prev_lt;
      logic [VALUE_WIDTH-1:0] prev_entry;
      logic [VALUE_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_head
         assign prev_lt    = 1'b1;
         assign prev_entry = key;
      end else begin : g_body
         assign prev_lt    = lt_vec[i-1];
         assign prev_entry = entries[i-1];
      end

      if (i == TABLE_DEPTH-1) begin : g_tail
         assign next_entry = entries[i];
      end else begin : g_inner
         assign next_entry = entries[i+1];
      end

      stid_cell #(
         .INDEX       (i),
         .TABLE_DEPTH (TABLE_DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key        (key),
         .count      (count),
         .prev_lt    (prev_lt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   // Result packing.
   assign rsp_tdata = {{(RSP_DATA_W-DATA_W-2*COUNT_W){1'b0}},
                       rsp_smallest, rsp_count, rsp_removed};

endmodule
